// ----- hw/rtl/sct_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types, constants and a helper function of the scroll camera tracker.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int SCREEN_BITS       = 13;
    localparam int SCREEN_WIDTH_DEF  = 240;
    localparam int SCREEN_HEIGHT_DEF = 160;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 72;
    localparam int FUNC_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [14:0] WORLD_W_RESET = 15'd240;
    localparam logic [14:0] WORLD_H_RESET = 15'd160;
    localparam logic [4:0]  SPEED_RESET   = 5'd8;

    localparam logic [31:0] LCG_MUL    = 32'd1664525;
    localparam logic [31:0] LCG_INC    = 32'd1013904223;
    localparam logic [31:0] SEED_RESET = 32'hDEADBEEF;

    typedef enum logic [FUNC_W-1:0] {
        FN_SET_POS = 3'd0,
        FN_FOLLOW  = 3'd1,
        FN_CENTRE  = 3'd2,
        FN_TICK    = 3'd3,
        FN_SCROLL  = 3'd4,
        FN_SHAKE   = 3'd5,
        FN_VISIBLE = 3'd6
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WORLD_W = 2'd0,
        CFG_WORLD_H = 2'd1,
        CFG_SPEED   = 2'd2,
        CFG_LOCK    = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        MUL_DX    = 2'd0,
        MUL_DY    = 2'd1,
        MUL_LCG   = 2'd2,
        MUL_NOISE = 2'd3
    } mul_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     ld_item;
        logic     exec;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     upd_x;
        logic     upd_y;
        logic     seed_upd;
        logic     ox_ld;
        logic     scroll_upd;
        logic     out_ld;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        func_t func;
        logic  lock;
        logic  shaking;
    } dp_status_t;

    // Clamps a position to 0..(world - screen), the upper bound saturating at 0.
    function automatic logic [14:0] clamp_axis(
        input logic signed [20:0]       v,
        input logic [14:0]              world,
        input logic [SCREEN_BITS-1:0]   screen
    );
        logic signed [16:0] hi;
        logic [14:0]        res;
        hi = $signed({2'b00, world}) - $signed({4'b0000, screen});
        if (hi < 0)
        begin
            hi = '0;
        end
        if (v < 0)
        begin
            res = '0;
        end
        else if (v > hi)
        begin
            res = hi[14:0];
        end
        else
        begin
            res = v[14:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/sct_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sct_ctrl
// Controller state machine: sequences one command through the datapath and
// owns the input ready and the output valid.
// ----------------------------------------------------------------------------
module sct_ctrl
    import sct_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    typedef enum logic [12:0] {
        ST_IDLE    = 13'b0000000000001,
        ST_EXEC    = 13'b0000000000010,
        ST_TICK_X  = 13'b0000000000100,
        ST_TICK_Y  = 13'b0000000001000,
        ST_TICK_W  = 13'b0000000010000,
        ST_LCG_1   = 13'b0000000100000,
        ST_SEED_1  = 13'b0000001000000,
        ST_NOISE_1 = 13'b0000010000000,
        ST_LCG_2   = 13'b0000100000000,
        ST_SEED_2  = 13'b0001000000000,
        ST_NOISE_2 = 13'b0010000000000,
        ST_SCROLL  = 13'b0100000000000,
        ST_FINISH  = 13'b1000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.mul_sel  = MUL_DX;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.ld_item = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if ((status.func == FN_TICK) && !status.lock)
                begin
                    state_next = ST_TICK_X;
                end
                else if ((status.func == FN_SCROLL) && status.shaking)
                begin
                    state_next = ST_LCG_1;
                end
                else if (status.func == FN_SCROLL)
                begin
                    state_next = ST_SCROLL;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_TICK_X:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DX;
                state_next  = ST_TICK_Y;
            end
            ST_TICK_Y:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DY;
                cmd.upd_x   = 1'b1;
                state_next  = ST_TICK_W;
            end
            ST_TICK_W:
            begin
                cmd.upd_y  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_LCG_1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LCG;
                state_next  = ST_SEED_1;
            end
            ST_SEED_1:
            begin
                cmd.seed_upd = 1'b1;
                state_next   = ST_NOISE_1;
            end
            ST_NOISE_1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_NOISE;
                state_next  = ST_LCG_2;
            end
            ST_LCG_2:
            begin
                cmd.ox_ld   = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LCG;
                state_next  = ST_SEED_2;
            end
            ST_SEED_2:
            begin
                cmd.seed_upd = 1'b1;
                state_next   = ST_NOISE_2;
            end
            ST_NOISE_2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_NOISE;
                state_next  = ST_SCROLL;
            end
            ST_SCROLL:
            begin
                cmd.scroll_upd = 1'b1;
                state_next     = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid_next = cmd.out_ld | (m_tvalid_reg & ~m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/sct_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sct_datapath
// Camera state, configuration registers, the shared multiplier and the
// output register.
// ----------------------------------------------------------------------------
module sct_datapath
    import sct_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [IN_DATA_W-1:0]  in_data,
    input  wire logic [FUNC_W-1:0]     in_func,
    input  wire ctrl_cmd_t             cmd,
    output dp_status_t                 status,
    output logic [OUT_DATA_W-1:0]      out_data
);

    localparam logic [SCREEN_BITS-1:0] SW     = SCREEN_BITS'(SCREEN_WIDTH);
    localparam logic [SCREEN_BITS-1:0] SH     = SCREEN_BITS'(SCREEN_HEIGHT);
    localparam logic signed [16:0]     HALF_W = 17'(SCREEN_WIDTH / 2);
    localparam logic signed [16:0]     HALF_H = 17'(SCREEN_HEIGHT / 2);

    // Latched item.
    func_t              func_reg;
    logic signed [15:0] cx_reg;
    logic signed [15:0] cy_reg;
    logic [9:0]         rw_reg;
    logic [9:0]         rh_reg;
    logic [7:0]         strength_reg;
    logic [7:0]         count_reg;

    // Configuration.
    logic [14:0] world_w_reg;
    logic [14:0] world_h_reg;
    logic [4:0]  speed_reg;
    logic        lock_reg;

    // Camera state.
    logic [14:0]        pos_x_reg;
    logic [14:0]        pos_y_reg;
    logic signed [16:0] goal_x_reg;
    logic signed [16:0] goal_y_reg;
    logic [7:0]         shake_level_reg;
    logic [7:0]         shake_left_reg;
    logic [31:0]        seed_reg;
    logic [8:0]         world_h_scroll_reg;
    logic [8:0]         world_v_scroll_reg;
    logic [8:0]         sky_h_scroll_reg;
    logic [8:0]         sky_v_scroll_reg;
    logic               vis_reg;

    logic [31:0]           prod_reg;
    logic [9:0]            ox_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic signed [17:0] dx;
    logic signed [17:0] dy;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic signed [20:0] cx_wide;
    logic signed [20:0] cy_wide;
    logic signed [20:0] tick_x;
    logic signed [20:0] tick_y;
    logic [14:0]        set_x;
    logic [14:0]        set_y;
    logic signed [17:0] cx_ext;
    logic signed [17:0] cy_ext;
    logic signed [17:0] right_edge;
    logic signed [17:0] bottom_edge;
    logic signed [17:0] screen_right;
    logic signed [17:0] screen_bottom;
    logic               vis;
    logic [9:0]         ox;
    logic [9:0]         oy;

    assign status.func    = func_reg;
    assign status.lock    = lock_reg;
    assign status.shaking = (shake_left_reg != 8'd0);
    assign out_data       = out_data_reg;

    // Shared multiplier operands; only the low 32 bits of the product are kept.
    assign dx = $signed({goal_x_reg[16], goal_x_reg}) - $signed({3'b000, pos_x_reg});
    assign dy = $signed({goal_y_reg[16], goal_y_reg}) - $signed({3'b000, pos_y_reg});

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_DX:
            begin
                mul_a = {{14{dx[17]}}, dx};
                mul_b = {27'd0, speed_reg};
            end
            MUL_DY:
            begin
                mul_a = {{14{dy[17]}}, dy};
                mul_b = {27'd0, speed_reg};
            end
            MUL_LCG:
            begin
                mul_a = seed_reg;
                mul_b = LCG_MUL;
            end
            default:
            begin
                mul_a = {{24{seed_reg[31]}}, seed_reg[31:24]};
                mul_b = {24'd0, shake_level_reg};
            end
        endcase
    end

    // Tick step: position plus the floored product over sixteen.
    assign tick_x = $signed({6'd0, pos_x_reg}) + $signed({{2{prod_reg[22]}}, prod_reg[22:4]});
    assign tick_y = $signed({6'd0, pos_y_reg}) + $signed({{2{prod_reg[22]}}, prod_reg[22:4]});

    assign cx_wide = {{5{cx_reg[15]}}, cx_reg};
    assign cy_wide = {{5{cy_reg[15]}}, cy_reg};
    assign set_x   = clamp_axis(cx_wide, world_w_reg, SW);
    assign set_y   = clamp_axis(cy_wide, world_h_reg, SH);

    // Visibility: the rectangle overlaps the screen window on both axes.
    assign cx_ext        = {{2{cx_reg[15]}}, cx_reg};
    assign cy_ext        = {{2{cy_reg[15]}}, cy_reg};
    assign right_edge    = cx_ext + $signed({8'd0, rw_reg});
    assign bottom_edge   = cy_ext + $signed({8'd0, rh_reg});
    assign screen_right  = $signed({3'b000, pos_x_reg}) + $signed({5'd0, SW});
    assign screen_bottom = $signed({3'b000, pos_y_reg}) + $signed({5'd0, SH});
    assign vis = (right_edge > $signed({3'b000, pos_x_reg})) && (cx_ext < screen_right) &&
                 (bottom_edge > $signed({3'b000, pos_y_reg})) && (cy_ext < screen_bottom);

    // Only the low ten bits of a scroll offset are ever seen.
    assign ox = status.shaking ? ox_reg : pos_x_reg[9:0];
    assign oy = status.shaking ? (pos_y_reg[9:0] + prod_reg[16:7]) : pos_y_reg[9:0];

    always_ff @(posedge clk)
    begin
        if (cmd.ld_item)
        begin
            func_reg     <= func_t'(in_func);
            cx_reg       <= in_data[15:0];
            cy_reg       <= in_data[31:16];
            rw_reg       <= in_data[41:32];
            rh_reg       <= in_data[51:42];
            strength_reg <= in_data[59:52];
            count_reg    <= in_data[67:60];
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.ox_ld)
        begin
            ox_reg <= pos_x_reg[9:0] + prod_reg[16:7];
        end
        if (cmd.out_ld)
        begin
            out_data_reg <= {5'd0, vis_reg, sky_v_scroll_reg, sky_h_scroll_reg,
                             world_v_scroll_reg, world_h_scroll_reg, pos_y_reg, pos_x_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            world_w_reg        <= WORLD_W_RESET;
            world_h_reg        <= WORLD_H_RESET;
            speed_reg          <= SPEED_RESET;
            lock_reg           <= 1'b0;
            pos_x_reg          <= '0;
            pos_y_reg          <= '0;
            goal_x_reg         <= '0;
            goal_y_reg         <= '0;
            shake_level_reg    <= '0;
            shake_left_reg     <= '0;
            seed_reg           <= SEED_RESET;
            world_h_scroll_reg <= '0;
            world_v_scroll_reg <= '0;
            sky_h_scroll_reg   <= '0;
            sky_v_scroll_reg   <= '0;
            vis_reg            <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_WORLD_W: world_w_reg <= cfg_data[14:0];
                    CFG_WORLD_H: world_h_reg <= cfg_data[14:0];
                    CFG_SPEED:   speed_reg   <= cfg_data[4:0];
                    CFG_LOCK:    lock_reg    <= cfg_data[0];
                endcase
            end
            if (cmd.exec)
            begin
                vis_reg <= (func_reg == FN_VISIBLE) ? vis : 1'b0;
                case (func_reg)
                    FN_SET_POS:
                    begin
                        pos_x_reg  <= set_x;
                        pos_y_reg  <= set_y;
                        goal_x_reg <= $signed({2'b00, set_x});
                        goal_y_reg <= $signed({2'b00, set_y});
                    end
                    FN_FOLLOW:
                    begin
                        goal_x_reg <= {cx_reg[15], cx_reg};
                        goal_y_reg <= {cy_reg[15], cy_reg};
                    end
                    FN_CENTRE:
                    begin
                        goal_x_reg <= $signed({cx_reg[15], cx_reg}) - HALF_W;
                        goal_y_reg <= $signed({cy_reg[15], cy_reg}) - HALF_H;
                    end
                    FN_SHAKE:
                    begin
                        shake_level_reg <= strength_reg;
                        shake_left_reg  <= count_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.upd_x)
            begin
                pos_x_reg <= clamp_axis(tick_x, world_w_reg, SW);
            end
            if (cmd.upd_y)
            begin
                pos_y_reg <= clamp_axis(tick_y, world_h_reg, SH);
            end
            if (cmd.seed_upd)
            begin
                seed_reg <= prod_reg + LCG_INC;
            end
            if (cmd.scroll_upd)
            begin
                world_h_scroll_reg <= ox[8:0];
                world_v_scroll_reg <= oy[8:0];
                sky_h_scroll_reg   <= ox[9:1];
                sky_v_scroll_reg   <= oy[9:1];
                if (status.shaking)
                begin
                    shake_left_reg <= shake_left_reg - 8'd1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/scroll_camera_tracker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scroll_camera_tracker
// 2-D scroll camera with follow, shake, layer scroll offsets and a
// rectangle visibility test.
// ----------------------------------------------------------------------------
// Use: each beat on the slave side carries one command in s_tuser, and every
// command yields exactly one result beat on the master side holding the
// camera position, the four layer scroll offsets of the last scroll frame and
// the visibility answer (zero for any command but the visibility test).
// Configuration (world size, follow speed, lock) is written on the cfg
// channel, which is always ready; write it only while no command is in flight.
// A set position, follow, centre, shake or visibility command and a locked
// tick go from the execute state straight to the finish state; a moving
// tick first steps the x and then the y axis, and a scroll frame updates its
// offsets in the scroll state, after two chained noise samples if shaking.
// The block passes through its idle state between items. The single shared
// 32-bit multiplier serves both tick axes and the two noise steps in turn.
// The block takes one command at a time; the result sits in an output
// register, so the next command is accepted while a result still waits. If
// the receiver stalls, the following result is held inside until the output
// register empties. Reset clears the camera, goal, shake and scroll state,
// reloads the noise seed and the configuration defaults, and drops m_tvalid.
// ----------------------------------------------------------------------------
module scroll_camera_tracker
    import sct_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration write channel.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // Command stream.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // coord_x[15:0], coord_y[31:16], rect_width[41:32], rect_height[51:42],
    // shake_strength[59:52], shake_count[67:60], zero padding[71:68]
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // func[2:0]
    input  wire logic [FUNC_W-1:0]     s_tuser,
    // Result stream.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // cam_pos_x[14:0], cam_pos_y[29:15], world_hscroll[38:30],
    // world_vscroll[47:39], sky_hscroll[56:48], sky_vscroll[65:57],
    // is_visible[66], zero padding[71:67]
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Register writes take effect at once and never stall.
    assign cfg_ready = 1'b1;

    // The controller sequences each command; the datapath holds the camera and configuration state.
    sct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sct_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .in_func   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .out_data  (m_tdata)
    );

endmodule
`default_nettype wire

// ----- hw/rtl/sct_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sct_checker
// Port-level checks of the scroll camera tracker, bound to the top level.
// ----------------------------------------------------------------------------
module sct_checker
    import sct_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata
);

    // A stalled result beat stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat withdrawn while stalled");

    // A stalled result beat keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result payload changed while stalled");

    // Commands are processed one at a time: no accept on the next edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command accepted on consecutive cycles");

    // The parallax offsets are the world offsets at half speed.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[55:48] == m_tdata[38:31]) &&
                     (m_tdata[64:57] == m_tdata[47:40]))
        else $error("parallax offset does not follow world offset");

endmodule

bind scroll_camera_tracker sct_checker u_sct_checker (.*);
`default_nettype wire

// ----- tb/sct_camera_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_camera_checker
// Watches the configuration, command and result channels of the scroll camera
// tracker, keeps its own model of the camera and compares every result beat
// field by field with the oldest predicted view.
// ----------------------------------------------------------------------------
module sct_camera_checker
    import sct_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic [FUNC_W-1:0]     s_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata,
    output int                         mismatches,
    output int                         outstanding,
    output int                         results_checked,
    output int                         shaken_frames,
    output int                         visible_hits
);

    typedef struct {
        logic [14:0] cam_x;
        logic [14:0] cam_y;
        logic [8:0]  world_h;
        logic [8:0]  world_v;
        logic [8:0]  sky_h;
        logic [8:0]  sky_v;
        logic        visible;
    } camera_view_t;

    // Register copies.
    logic [14:0]        world_w_q;
    logic [14:0]        world_h_q;
    logic [4:0]         gain_q;
    logic               lock_q;

    // Camera state.
    logic [14:0]        cam_x;
    logic [14:0]        cam_y;
    logic signed [16:0] goal_x;
    logic signed [16:0] goal_y;
    logic [7:0]         shake_level;
    logic [7:0]         shake_left;
    logic [31:0]        noise_seed;
    logic [8:0]         scroll_q [4];

    camera_view_t       pending_views [$];

    function automatic logic [14:0] clamp_to_world(input longint v, input logic [14:0] world,
                                                   input int screen);
        longint hi;
        hi = longint'(world) - screen;
        if (hi < 0)
        begin
            hi = 0;
        end
        if (v < 0)
        begin
            return '0;
        end
        if (v > hi)
        begin
            return hi[14:0];
        end
        return v[14:0];
    endfunction

    // One LCG step; the top byte is a signed noise sample scaled by the level.
    function automatic longint shake_offset();
        logic signed [7:0] noise;
        noise_seed = noise_seed * LCG_MUL + LCG_INC;
        noise = noise_seed[31:24];
        return (longint'(noise) * longint'(shake_level)) >>> 7;
    endfunction

    function automatic camera_view_t advance_camera(input logic [FUNC_W-1:0] op,
                                                    input logic [IN_DATA_W-1:0] d);
        camera_view_t v;
        longint cx;
        longint cy;
        longint rw;
        longint rh;
        longint px;
        longint py;
        longint ox;
        longint oy;
        longint half_x;
        longint half_y;
        cx = longint'($signed(d[15:0]));
        cy = longint'($signed(d[31:16]));
        rw = longint'(d[41:32]);
        rh = longint'(d[51:42]);
        px = longint'(cam_x);
        py = longint'(cam_y);
        v.visible = 1'b0;
        case (op)
            FN_SET_POS:
            begin
                cam_x  = clamp_to_world(cx, world_w_q, SCREEN_WIDTH_DEF);
                cam_y  = clamp_to_world(cy, world_h_q, SCREEN_HEIGHT_DEF);
                goal_x = $signed({2'b00, cam_x});
                goal_y = $signed({2'b00, cam_y});
            end
            FN_FOLLOW:
            begin
                goal_x = cx[16:0];
                goal_y = cy[16:0];
            end
            FN_CENTRE:
            begin
                ox     = cx - SCREEN_WIDTH_DEF / 2;
                oy     = cy - SCREEN_HEIGHT_DEF / 2;
                goal_x = ox[16:0];
                goal_y = oy[16:0];
            end
            FN_TICK:
            begin
                if (!lock_q)
                begin
                    // Floored step towards the goal, then clamped to the world.
                    ox = px + (((longint'(goal_x) - px) * longint'(gain_q)) >>> 4);
                    oy = py + (((longint'(goal_y) - py) * longint'(gain_q)) >>> 4);
                    cam_x = clamp_to_world(ox, world_w_q, SCREEN_WIDTH_DEF);
                    cam_y = clamp_to_world(oy, world_h_q, SCREEN_HEIGHT_DEF);
                end
            end
            FN_SCROLL:
            begin
                ox = px;
                oy = py;
                if (shake_left != 0)
                begin
                    ox += shake_offset();
                    oy += shake_offset();
                    shake_left--;
                    shaken_frames++;
                end
                half_x = ox >>> 1;
                half_y = oy >>> 1;
                scroll_q[0] = ox[8:0];
                scroll_q[1] = oy[8:0];
                scroll_q[2] = half_x[8:0];
                scroll_q[3] = half_y[8:0];
            end
            FN_SHAKE:
            begin
                shake_level = d[59:52];
                shake_left  = d[67:60];
            end
            FN_VISIBLE:
            begin
                v.visible = (cx + rw > px) && (cx < px + SCREEN_WIDTH_DEF) &&
                            (cy + rh > py) && (cy < py + SCREEN_HEIGHT_DEF);
                if (v.visible)
                begin
                    visible_hits++;
                end
            end
            default:
            begin
                // The spare selector leaves everything as it is.
            end
        endcase
        v.cam_x   = cam_x;
        v.cam_y   = cam_y;
        v.world_h = scroll_q[0];
        v.world_v = scroll_q[1];
        v.sky_h   = scroll_q[2];
        v.sky_v   = scroll_q[3];
        return v;
    endfunction

    task automatic compare_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        camera_view_t want;
        if (!rst_n)
        begin
            world_w_q       = WORLD_W_RESET;
            world_h_q       = WORLD_H_RESET;
            gain_q          = SPEED_RESET;
            lock_q          = 1'b0;
            cam_x           = '0;
            cam_y           = '0;
            goal_x          = '0;
            goal_y          = '0;
            shake_level     = '0;
            shake_left      = '0;
            noise_seed      = SEED_RESET;
            scroll_q        = '{default: '0};
            pending_views.delete();
            mismatches      = 0;
            outstanding     = 0;
            results_checked = 0;
            shaken_frames   = 0;
            visible_hits    = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_WORLD_W: world_w_q = cfg_data;
                    CFG_WORLD_H: world_h_q = cfg_data;
                    CFG_SPEED:   gain_q    = cfg_data[4:0];
                    CFG_LOCK:    lock_q    = cfg_data[0];
                    default:     ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                pending_views.push_back(advance_camera(s_tuser, s_tdata));
            end
            if (m_tvalid && m_tready)
            begin
                if (pending_views.size() == 0)
                begin
                    $display("%0t: result beat %h with no command waiting for it", $time,
                             m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = pending_views.pop_front();
                    compare_field("cam_pos_x", want.cam_x, m_tdata[14:0]);
                    compare_field("cam_pos_y", want.cam_y, m_tdata[29:15]);
                    compare_field("world_hscroll", want.world_h, m_tdata[38:30]);
                    compare_field("world_vscroll", want.world_v, m_tdata[47:39]);
                    compare_field("sky_hscroll", want.sky_h, m_tdata[56:48]);
                    compare_field("sky_vscroll", want.sky_v, m_tdata[65:57]);
                    compare_field("is_visible", want.visible, m_tdata[66]);
                    compare_field("padding", 0, m_tdata[71:67]);
                    results_checked++;
                end
            end
            outstanding = pending_views.size();
        end
    end

endmodule

// ----- tb/tb_scroll_camera_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scroll_camera_tracker
// Drives the scroll camera tracker with a directed command sequence and then
// with random phases under several register settings and idling patterns; the
// checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_scroll_camera_tracker
    import sct_pkg::*;
();

    // The spare selector value has no command behind it.
    localparam logic [FUNC_W-1:0] FN_SPARE = 3'd7;

    localparam int NUM_PHASES       = 13;
    localparam int CMDS_PER_PHASE   = 118;
    localparam int CYCLE_LIMIT      = 600000;
    localparam int SETTLE_CYCLES    = 16;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [FUNC_W-1:0]     s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b1;
    logic [OUT_DATA_W-1:0] m_tdata;

    int         mismatches;
    int         outstanding;
    int         results_checked;
    int         shaken_frames;
    int         visible_hits;
    int         cycle_count = 0;
    int         cmds_sent = 0;
    idle_mode_t idle_mode = IDLE_NONE;

    // World size of the current phase, so that coordinates mostly land near it.
    int         span_x = 240;
    int         span_y = 160;

    always #1 clk = ~clk;

    scroll_camera_tracker DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    sct_camera_checker u_camera_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .shaken_frames   (shaken_frames),
        .visible_hits    (visible_hits)
    );

    // A hung block must not keep the simulator busy for ever.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, outstanding);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side back-pressure. It is redrawn at every falling edge, so a
    // stall can land on any phase of the block's work.
    always @(negedge clk)
    begin
        case (idle_mode)
            IDLE_RECEIVER: m_tready <= ($urandom_range(99, 0) >= 88);
            IDLE_BOTH:     m_tready <= ($urandom_range(99, 0) >= 31);
            default:       m_tready <= 1'b1;
        endcase
    end

    // Sends one command beat. Called at a falling edge and returns at one.
    // Valid stays high from one beat to the next unless a gap is drawn.
    task automatic issue(input logic [FUNC_W-1:0] op, input logic [15:0] x,
                         input logic [15:0] y, input logic [9:0] w, input logic [9:0] h,
                         input logic [7:0] strength, input logic [7:0] frames);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SENDER) ? 88 : (idle_mode == IDLE_BOTH) ? 31 : 0;
        while ($urandom_range(99, 0) < gap_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {4'b0000, frames, strength, h, w, y, x};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        cmds_sent++;
        @(negedge clk);
    endtask

    // Drops valid and waits until every command has produced its result, so
    // that the block is idle and its registers may be written.
    task automatic drain();
        s_tvalid = 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Mostly near the world, now and then anywhere in the 16-bit range.
    function automatic logic [15:0] pick_coord(input int span);
        if ($urandom_range(4, 0) == 0)
        begin
            return 16'($urandom_range(65535, 0));
        end
        return 16'(int'($urandom_range(span + 300, 0)) - 150);
    endfunction

    task automatic random_command();
        int                pick;
        logic [FUNC_W-1:0] op;
        logic [7:0]        frames;
        pick = $urandom_range(99, 0);
        if (pick < 8)
        begin
            op = FN_SET_POS;
        end
        else if (pick < 18)
        begin
            op = FN_FOLLOW;
        end
        else if (pick < 26)
        begin
            op = FN_CENTRE;
        end
        else if (pick < 52)
        begin
            op = FN_TICK;
        end
        else if (pick < 76)
        begin
            op = FN_SCROLL;
        end
        else if (pick < 83)
        begin
            op = FN_SHAKE;
        end
        else if (pick < 97)
        begin
            op = FN_VISIBLE;
        end
        else
        begin
            op = FN_SPARE;
        end
        // Short shakes keep most scroll frames shaking; long ones still occur.
        frames = ($urandom_range(9, 0) == 0) ? 8'($urandom_range(255, 0))
                                             : 8'($urandom_range(24, 0));
        issue(op, pick_coord(span_x), pick_coord(span_y), 10'($urandom_range(1023, 0)),
              10'($urandom_range(1023, 0)), 8'($urandom_range(255, 0)), frames);
    endtask

    // Every phase rewrites all four registers. The early phases take the reset
    // values and the extremes; the rest are drawn at random.
    task automatic configure_phase(input int phase);
        logic [14:0] ww;
        logic [14:0] wh;
        logic [4:0]  speed;
        logic        lock;
        ww    = 15'($urandom_range(2400, 240));
        wh    = 15'($urandom_range(1600, 160));
        speed = 5'($urandom_range(16, 1));
        lock  = ($urandom_range(7, 0) == 0);
        case (phase)
            0:
            begin
                ww = WORLD_W_RESET;
                wh = WORLD_H_RESET;
                speed = SPEED_RESET;
                lock = 1'b0;
            end
            1:
            begin
                ww = 15'h7FFF;
                wh = 15'h7FFF;
                speed = 5'd16;
                lock = 1'b0;
            end
            2:
            begin
                // World smaller than the screen: the camera is pinned at zero.
                ww = 15'($urandom_range(239, 0));
                wh = 15'($urandom_range(159, 0));
                speed = 5'd31;
            end
            3:
            begin
                lock = 1'b1;
            end
            4:
            begin
                speed = 5'd0;
                lock = 1'b0;
            end
            5:
            begin
                ww = 15'($urandom_range(32767, 240));
                wh = 15'($urandom_range(32767, 160));
                speed = 5'($urandom_range(31, 17));
            end
            default:
            begin
            end
        endcase
        write_reg(CFG_WORLD_W, ww);
        write_reg(CFG_WORLD_H, wh);
        write_reg(CFG_SPEED, {10'd0, speed});
        write_reg(CFG_LOCK, {14'd0, lock});
        span_x = ww;
        span_y = wh;
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part, first with the reset registers: the world is exactly
        // the screen, so every placement clamps to the origin.
        issue(FN_SCROLL, 16'd0, 16'd0, 10'd0, 10'd0, 8'd0, 8'd0);
        issue(FN_SET_POS, 16'h7FFF, 16'h7FFF, 10'd0, 10'd0, 8'd0, 8'd0);
        issue(FN_VISIBLE, 16'h8000, 16'h8000, 10'h3FF, 10'h3FF, 8'd0, 8'd0);
        issue(FN_VISIBLE, 16'd239, 16'd159, 10'd0, 10'd0, 8'd0, 8'd0);
        drain();

        // Largest world, so that positions and goals can reach far.
        write_reg(CFG_WORLD_W, 15'h7FFF);
        write_reg(CFG_WORLD_H, 15'h7FFF);
        issue(FN_SET_POS, 16'h7FFF, 16'h7FFF, 10'd0, 10'd0, 8'd0, 8'd0);
        issue(FN_SCROLL, 16'd0, 16'd0, 10'd0, 10'd0, 8'd0, 8'd0);
        issue(FN_SET_POS, 16'h8000, 16'h8000, 10'd0, 10'd0, 8'd0, 8'd0);
        issue(FN_SET_POS, 16'd1000, 16'd600, 10'd0, 10'd0, 8'd0, 8'd0);
        issue(FN_SCROLL, 16'd0, 16'd0, 10'd0, 10'd0, 8'd0, 8'd0);
        issue(FN_FOLLOW, 16'd1400, 16'd300, 10'd0, 10'd0, 8'd0, 8'd0);
        issue(FN_TICK, 16'd0, 16'd0, 10'd0, 10'd0, 8'd0, 8'd0);
        issue(FN_TICK, 16'd0, 16'd0, 10'd0, 10'd0, 8'd0, 8'd0);
        // A goal far below zero: the tick must clamp at the world edge.
        issue(FN_CENTRE, 16'h8000, 16'h8000, 10'd0, 10'd0, 8'd0, 8'd0);
        issue(FN_TICK, 16'd0, 16'd0, 10'd0, 10'd0, 8'd0, 8'd0);
        // Three shaken frames near the origin give negative, wrapped offsets,
        // and the fourth frame is still again.
        issue(FN_SHAKE, 16'd0, 16'd0, 10'd0, 10'd0, 8'hFF, 8'd3);
        repeat (4) issue(FN_SCROLL, 16'd0, 16'd0, 10'd0, 10'd0, 8'd0, 8'd0);
        // A rectangle ending exactly where the screen begins is not visible.
        issue(FN_VISIBLE, 16'hFFF6, 16'd0, 10'd10, 10'd10, 8'd0, 8'd0);
        issue(FN_SPARE, 16'hFFFF, 16'hFFFF, 10'h3FF, 10'h3FF, 8'hFF, 8'hFF);
        issue(FN_SHAKE, 16'd0, 16'd0, 10'd0, 10'd0, 8'd0, 8'd0);
        drain();

        // A locked camera ignores ticks.
        write_reg(CFG_LOCK, 15'd1);
        issue(FN_FOLLOW, 16'd500, 16'd500, 10'd0, 10'd0, 8'd0, 8'd0);
        issue(FN_TICK, 16'd0, 16'd0, 10'd0, 10'd0, 8'd0, 8'd0);
        drain();

        // A gain above sixteen overshoots the goal.
        write_reg(CFG_LOCK, 15'd0);
        write_reg(CFG_SPEED, 15'd31);
        issue(FN_TICK, 16'd0, 16'd0, 10'd0, 10'd0, 8'd0, 8'd0);
        drain();

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain();
            idle_mode = idle_mode_t'(phase % 4);
            configure_phase(phase);
            for (int n = 0; n < CMDS_PER_PHASE; n++)
            begin
                random_command();
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Sent %0d commands over %0d register settings and four idling patterns,",
                 cmds_sent, NUM_PHASES + 4);
        $display("checked %0d results, %0d shaken scroll frames, %0d visible rectangles.",
                 results_checked, shaken_frames, visible_hits);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
